>>> rtl/core/obbsat_pkg.sv
`default_nettype none
package obbsat_pkg;

    localparam int POS_W  = 24;
    localparam int AXIS_W = 16;
    localparam int HALF_W = 23;
    localparam int DIFF_W = POS_W + 1;

    // product and magnitude widths inside the axis unit
    localparam int PD_W   = DIFF_W + AXIS_W;       // centre diff times axis component
    localparam int PA_W   = 2 * AXIS_W;            // axis times axis component
    localparam int MAGD_W = PD_W;                  // |sum of two PD products|
    localparam int MAGA_W = PA_W;                  // |sum of two PA products|
    localparam int SHD    = 14;                    // Q.26 -> Q.40
    localparam int SHH    = 28;                    // Q.12 -> Q.40
    localparam int SUM_W  = 57;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_t;

    // one candidate axis handed to the shared unit
    typedef struct packed {
        logic                     valid;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic        [HALF_W-1:0] own_half;
        logic signed [AXIS_W-1:0] o_ux;
        logic signed [AXIS_W-1:0] o_uy;
        logic signed [AXIS_W-1:0] o_vx;
        logic signed [AXIS_W-1:0] o_vy;
        logic        [HALF_W-1:0] o_hu;
        logic        [HALF_W-1:0] o_hv;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } axis_req_t;

    typedef struct packed {
        logic valid;
        logic sep;
    } axis_res_t;

endpackage
`default_nettype wire

>>> rtl/core/obb_overlap_test_2d.sv
`default_nettype none
// Oriented-box overlap test in 2D by separating axes.
// Command channel: an item is taken when start is high and busy is low.
// command = CMD_LOAD stores the box as the reference box; busy stays low and
// no result is produced. command = CMD_TEST checks the box against the stored
// reference on four axes: reference u, reference v, test u, test v.
// Result channel: overlap is valid for one cycle while done is high; there is
// no back-pressure, so the receiver must take it in that cycle.
// Sequencing: busy stays high from acceptance of a test until done rises, so
// a new test is accepted only after the previous one has finished. The four
// axes are issued on consecutive cycles into one shared 4-stage axis unit (six
// dot-product multipliers, sums and magnitudes, two radius multipliers, then
// add/compare); done rises once all four axis results have come back.
// Reset: the reference box clears to all zero. A test never changes the
// reference.
module obb_overlap_test_2d
    import obbsat_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     command,
    input  wire logic signed [POS_W-1:0]  center_x,
    input  wire logic signed [POS_W-1:0]  center_y,
    input  wire logic signed [AXIS_W-1:0] axis_u_x,
    input  wire logic signed [AXIS_W-1:0] axis_u_y,
    input  wire logic signed [AXIS_W-1:0] axis_v_x,
    input  wire logic signed [AXIS_W-1:0] axis_v_y,
    input  wire logic        [HALF_W-1:0] half_u,
    input  wire logic        [HALF_W-1:0] half_v,
    output logic                          done,
    output logic                          overlap
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic signed [POS_W-1:0]  ref_cx_reg, ref_cy_reg;
    logic signed [AXIS_W-1:0] ref_ux_reg, ref_uy_reg, ref_vx_reg, ref_vy_reg;
    logic        [HALF_W-1:0] ref_hu_reg, ref_hv_reg;

    logic signed [AXIS_W-1:0] tst_ux_reg, tst_uy_reg, tst_vx_reg, tst_vy_reg;
    logic        [HALF_W-1:0] tst_hu_reg, tst_hv_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;

    logic [1:0] issue_cnt_reg, issue_cnt_next;
    logic [1:0] rcv_cnt_reg, rcv_cnt_next;
    logic       sep_acc_reg, sep_acc_next;
    logic       done_reg, done_next;
    logic       overlap_reg, overlap_next;

    logic      accept;
    axis_req_t axis_req;
    axis_res_t axis_res;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        axis_req       = '0;
        axis_req.valid = (state_reg == ST_ISSUE);
        axis_req.dx    = dx_reg;
        axis_req.dy    = dy_reg;
        if (!issue_cnt_reg[1])
        begin
            // reference axis, radius from the test box
            axis_req.ax       = issue_cnt_reg[0] ? ref_vx_reg : ref_ux_reg;
            axis_req.ay       = issue_cnt_reg[0] ? ref_vy_reg : ref_uy_reg;
            axis_req.own_half = issue_cnt_reg[0] ? ref_hv_reg : ref_hu_reg;
            axis_req.o_ux     = tst_ux_reg;
            axis_req.o_uy     = tst_uy_reg;
            axis_req.o_vx     = tst_vx_reg;
            axis_req.o_vy     = tst_vy_reg;
            axis_req.o_hu     = tst_hu_reg;
            axis_req.o_hv     = tst_hv_reg;
        end
        else
        begin
            axis_req.ax       = issue_cnt_reg[0] ? tst_vx_reg : tst_ux_reg;
            axis_req.ay       = issue_cnt_reg[0] ? tst_vy_reg : tst_uy_reg;
            axis_req.own_half = issue_cnt_reg[0] ? tst_hv_reg : tst_hu_reg;
            axis_req.o_ux     = ref_ux_reg;
            axis_req.o_uy     = ref_uy_reg;
            axis_req.o_vx     = ref_vx_reg;
            axis_req.o_vy     = ref_vy_reg;
            axis_req.o_hu     = ref_hu_reg;
            axis_req.o_hv     = ref_hv_reg;
        end
    end

    obbsat_axis_unit u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (axis_req),
        .res   (axis_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        sep_acc_next   = sep_acc_reg;
        done_next      = 1'b0;
        overlap_next   = overlap_reg;

        if (axis_res.valid)
        begin
            rcv_cnt_next = rcv_cnt_reg + 2'd1;
            sep_acc_next = sep_acc_reg | axis_res.sep;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_TEST)
                begin
                    state_next     = ST_ISSUE;
                    issue_cnt_next = '0;
                    rcv_cnt_next   = '0;
                    sep_acc_next   = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                issue_cnt_next = issue_cnt_reg + 2'd1;
                if (issue_cnt_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (axis_res.valid && rcv_cnt_reg == 2'd3)
                begin
                    state_next   = ST_IDLE;
                    done_next    = 1'b1;
                    overlap_next = !(sep_acc_reg | axis_res.sep);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rcv_cnt_reg   <= '0;
            sep_acc_reg   <= 1'b0;
            done_reg      <= 1'b0;
            overlap_reg   <= 1'b0;
            ref_cx_reg    <= '0;
            ref_cy_reg    <= '0;
            ref_ux_reg    <= '0;
            ref_uy_reg    <= '0;
            ref_vx_reg    <= '0;
            ref_vy_reg    <= '0;
            ref_hu_reg    <= '0;
            ref_hv_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            sep_acc_reg   <= sep_acc_next;
            done_reg      <= done_next;
            overlap_reg   <= overlap_next;
            if (accept && command == CMD_LOAD)
            begin
                ref_cx_reg <= center_x;
                ref_cy_reg <= center_y;
                ref_ux_reg <= axis_u_x;
                ref_uy_reg <= axis_u_y;
                ref_vx_reg <= axis_v_x;
                ref_vy_reg <= axis_v_y;
                ref_hu_reg <= half_u;
                ref_hv_reg <= half_v;
            end
        end
    end

    // test box is captured at accept; centre difference is formed once
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_TEST)
        begin
            tst_ux_reg <= axis_u_x;
            tst_uy_reg <= axis_u_y;
            tst_vx_reg <= axis_v_x;
            tst_vy_reg <= axis_v_y;
            tst_hu_reg <= half_u;
            tst_hv_reg <= half_v;
            dx_reg     <= {ref_cx_reg[POS_W-1], ref_cx_reg} - {center_x[POS_W-1], center_x};
            dy_reg     <= {ref_cy_reg[POS_W-1], ref_cy_reg} - {center_y[POS_W-1], center_y};
        end
    end

    assign done    = done_reg;
    assign overlap = overlap_reg;

    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_DRAIN))
        else $error("result strobe without a finished test");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_LOAD) |=> !done_reg)
        else $error("load item produced a result");

    a_issue_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE && issue_cnt_reg == 2'd3) |=> (state_reg == ST_DRAIN))
        else $error("sequencer did not leave issue after four axes");

    a_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        axis_res.valid |-> busy)
        else $error("axis result while idle");

endmodule
`default_nettype wire

>>> rtl/core/obbsat_axis_unit.sv
`default_nettype none
module obbsat_axis_unit
    import obbsat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire axis_req_t req,
    output axis_res_t      res
);

    // stage 1: six dot-product multipliers
    logic                     s1_valid_reg;
    logic signed [PD_W-1:0]   s1_pdx_reg, s1_pdy_reg;
    logic signed [PA_W-1:0]   s1_puu_reg, s1_puv_reg, s1_pvu_reg, s1_pvv_reg;
    logic        [HALF_W-1:0] s1_own_reg, s1_hu_reg, s1_hv_reg;

    // stage 2: sums and magnitudes
    logic                     s2_valid_reg;
    logic        [MAGD_W-1:0] s2_magd_reg;
    logic        [MAGA_W-1:0] s2_magu_reg, s2_magv_reg;
    logic        [HALF_W-1:0] s2_own_reg, s2_hu_reg, s2_hv_reg;

    // stage 3: scale to Q.40, radius products
    logic                     s3_valid_reg;
    logic        [SUM_W-1:0]  s3_dist_reg, s3_r1_reg, s3_ru_reg, s3_rv_reg;

    logic                     out_valid_reg, out_sep_reg;

    logic signed [PD_W:0]     sum_d;
    logic signed [PA_W:0]     sum_u, sum_v;
    logic signed [PD_W:0]     neg_d;
    logic signed [PA_W:0]     neg_u, neg_v;
    logic        [MAGD_W-1:0] magd_next;
    logic        [MAGA_W-1:0] magu_next, magv_next;
    logic        [SUM_W-1:0]  radius;

    always_comb
    begin
        sum_d = PD_W'(s1_pdx_reg) + PD_W'(s1_pdy_reg);
        sum_d = {s1_pdx_reg[PD_W-1], s1_pdx_reg} + {s1_pdy_reg[PD_W-1], s1_pdy_reg};
        sum_u = {s1_puu_reg[PA_W-1], s1_puu_reg} + {s1_puv_reg[PA_W-1], s1_puv_reg};
        sum_v = {s1_pvu_reg[PA_W-1], s1_pvu_reg} + {s1_pvv_reg[PA_W-1], s1_pvv_reg};
        neg_d = -sum_d;
        neg_u = -sum_u;
        neg_v = -sum_v;
        magd_next = sum_d[PD_W] ? neg_d[MAGD_W-1:0] : sum_d[MAGD_W-1:0];
        magu_next = sum_u[PA_W] ? neg_u[MAGA_W-1:0] : sum_u[MAGA_W-1:0];
        magv_next = sum_v[PA_W] ? neg_v[MAGA_W-1:0] : sum_v[MAGA_W-1:0];
    end

    assign radius = s3_r1_reg + s3_ru_reg + s3_rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pdx_reg <= PD_W'(req.dx * req.ax);
        s1_pdy_reg <= PD_W'(req.dy * req.ay);
        s1_puu_reg <= PA_W'(req.o_ux * req.ax);
        s1_puv_reg <= PA_W'(req.o_uy * req.ay);
        s1_pvu_reg <= PA_W'(req.o_vx * req.ax);
        s1_pvv_reg <= PA_W'(req.o_vy * req.ay);
        s1_own_reg <= req.own_half;
        s1_hu_reg  <= req.o_hu;
        s1_hv_reg  <= req.o_hv;

        s2_magd_reg <= magd_next;
        s2_magu_reg <= magu_next;
        s2_magv_reg <= magv_next;
        s2_own_reg  <= s1_own_reg;
        s2_hu_reg   <= s1_hu_reg;
        s2_hv_reg   <= s1_hv_reg;

        s3_dist_reg <= SUM_W'(s2_magd_reg) << SHD;
        s3_r1_reg   <= SUM_W'(s2_own_reg) << SHH;
        s3_ru_reg   <= SUM_W'(s2_magu_reg * s2_hu_reg);
        s3_rv_reg   <= SUM_W'(s2_magv_reg * s2_hv_reg);

        // strict excess separates; touching counts as overlap
        out_sep_reg <= s3_dist_reg > radius;
    end

    assign res.valid = out_valid_reg;
    assign res.sep   = out_sep_reg;

endmodule
`default_nettype wire
